// ----- src/filtered_top_n_sorter_defines.svh -----
// ----------------------------------------------------------------------------
// Filtered top-N sorter assertion macros
// Shared concurrent assertion helpers, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FILTERED_TOP_N_SORTER_DEFINES_SVH
`define FILTERED_TOP_N_SORTER_DEFINES_SVH
`ifndef SYNTHESIS
`define FTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fts assertion failed");
`define FTS_ASSERT_NEXT(lbl, a, b) \
    `FTS_ASSERT(lbl, (a) |=> (b))
`else
`define FTS_ASSERT(lbl, prop)
`define FTS_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ----- src/fts_pkg.sv -----
// ----------------------------------------------------------------------------
// Filtered top-N sorter package
// Field widths, register map, configuration and control types.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int EnergyW       = 13;
    localparam int EtaW          = 9;
    localparam int PhiW          = 7;
    localparam int EntryW        = EnergyW + EtaW + PhiW;
    localparam int DefStoreDepth = 64;
    localparam int MaxResults    = 64;
    localparam int PAddrW        = 5;
    localparam int PDataW        = 32;

    localparam logic [2:0] REG_KEEP  = 3'd0;
    localparam logic [2:0] REG_ETALO = 3'd1;
    localparam logic [2:0] REG_ETAHI = 3'd2;
    localparam logic [2:0] REG_ISO   = 3'd3;
    localparam logic [2:0] REG_FRAC1 = 3'd4;
    localparam logic [2:0] REG_FRAC2 = 3'd5;

    localparam logic [5:0] RstKeep  = 6'd10;
    localparam logic [7:0] RstEtaLo = 8'd0;
    localparam logic [7:0] RstEtaHi = 8'd196;

    typedef struct packed {
        logic [5:0] keep_count;
        logic [7:0] eta_low;
        logic [7:0] eta_high;
        logic [1:0] iso_min;
        logic [1:0] frac1_min;
        logic [1:0] frac2_min;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_FIN,
        ST_EMPTY,
        ST_TIE_RD0,
        ST_TIE_RD1,
        ST_TIE_CMP,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } t_state;

    typedef enum logic [1:0] {
        RS_PREV,
        RS_KEEP,
        RS_KEEPM1,
        RS_K
    } t_rsel;

    typedef struct packed {
        logic  load;
        logic  place;
        logic  shift;
        logic  fin;
        logic  tie_cap;
        logic  tie_cmp;
        logic  out_load;
        logic  empty_load;
        t_rsel rsel;
    } t_cmd;

    typedef struct packed {
        logic in_pass;
        logic in_last;
        logic item_last;
        logic at_zero;
        logic less;
        logic fin_empty;
        logic fin_tie;
        logic out_taken;
        logic out_final;
    } t_sts;

endpackage

// ----- src/fts_ifs.sv -----
// ----------------------------------------------------------------------------
// Filtered top-N sorter channels
// Valid/ready channels for trigger objects and ranked results.
// ----------------------------------------------------------------------------
interface fts_obj_if;
    logic              valid;
    logic              ready;
    logic [12:0]       energy;
    logic signed [8:0] eta_pos;
    logic [6:0]        phi_pos;
    logic [1:0]        iso_word;
    logic [1:0]        frac1_word;
    logic [1:0]        frac2_word;
    logic              end_of_list;

    modport source (output valid, energy, eta_pos, phi_pos, iso_word, frac1_word,
                    frac2_word, end_of_list, input ready);
    modport sink (input valid, energy, eta_pos, phi_pos, iso_word, frac1_word,
                  frac2_word, end_of_list, output ready);
endinterface

interface fts_res_if;
    logic              valid;
    logic              ready;
    logic [12:0]       out_energy;
    logic signed [8:0] out_eta;
    logic [6:0]        out_phi;
    logic              tie_at_cut;
    logic              list_empty;
    logic              final_entry;

    modport source (output valid, out_energy, out_eta, out_phi, tie_at_cut, list_empty,
                    final_entry, input ready);
    modport sink (input valid, out_energy, out_eta, out_phi, tie_at_cut, list_empty,
                  final_entry, output ready);
endinterface

// ----- src/fts_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/fts_cfg.sv -----
// ----------------------------------------------------------------------------
// Filtered top-N sorter configuration registers
// APB-style register file holding the keep count and selection cuts.
// ----------------------------------------------------------------------------
module fts_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fts_pkg::PAddrW-1:0]  paddr,
    input  logic [fts_pkg::PDataW-1:0]  pwdata,
    output logic [fts_pkg::PDataW-1:0]  prdata,
    output logic                        pready,
    output fts_pkg::t_cfg               o_cfg
);
    fts_pkg::t_cfg r_cfg;
    logic [2:0]    idx;
    logic          wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keep_count <= fts_pkg::RstKeep;
            r_cfg.eta_low    <= fts_pkg::RstEtaLo;
            r_cfg.eta_high   <= fts_pkg::RstEtaHi;
            r_cfg.iso_min    <= 2'd0;
            r_cfg.frac1_min  <= 2'd0;
            r_cfg.frac2_min  <= 2'd0;
        end else if (wr) begin
            unique case (idx)
                fts_pkg::REG_KEEP:  r_cfg.keep_count <= pwdata[5:0];
                fts_pkg::REG_ETALO: r_cfg.eta_low    <= pwdata[7:0];
                fts_pkg::REG_ETAHI: r_cfg.eta_high   <= pwdata[7:0];
                fts_pkg::REG_ISO:   r_cfg.iso_min    <= pwdata[1:0];
                fts_pkg::REG_FRAC1: r_cfg.frac1_min  <= pwdata[1:0];
                fts_pkg::REG_FRAC2: r_cfg.frac2_min  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            fts_pkg::REG_KEEP:  prdata = {26'd0, r_cfg.keep_count};
            fts_pkg::REG_ETALO: prdata = {24'd0, r_cfg.eta_low};
            fts_pkg::REG_ETAHI: prdata = {24'd0, r_cfg.eta_high};
            fts_pkg::REG_ISO:   prdata = {30'd0, r_cfg.iso_min};
            fts_pkg::REG_FRAC1: prdata = {30'd0, r_cfg.frac1_min};
            fts_pkg::REG_FRAC2: prdata = {30'd0, r_cfg.frac2_min};
            default:            prdata = '0;
        endcase
    end
endmodule

// ----- src/fts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Filtered top-N sorter controller
// Sequences insertion, end-of-list tie check and result emission.
// ----------------------------------------------------------------------------
module fts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fts_pkg::t_sts i_sts,
    output fts_pkg::t_cmd o_cmd
);
    fts_pkg::t_state r_state;
    fts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fts_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_pass) begin
                        n_state = fts_pkg::ST_INS_RD;
                    end else if (i_sts.in_last) begin
                        n_state = fts_pkg::ST_FIN;
                    end
                end
            end
            fts_pkg::ST_INS_RD: begin
                if (!i_sts.at_zero) begin
                    n_state = fts_pkg::ST_INS_CMP;
                end else if (i_sts.item_last) begin
                    n_state = fts_pkg::ST_FIN;
                end else begin
                    n_state = fts_pkg::ST_IDLE;
                end
            end
            fts_pkg::ST_INS_CMP: begin
                if (i_sts.less) begin
                    n_state = fts_pkg::ST_INS_RD;
                end else if (i_sts.item_last) begin
                    n_state = fts_pkg::ST_FIN;
                end else begin
                    n_state = fts_pkg::ST_IDLE;
                end
            end
            fts_pkg::ST_FIN: begin
                if (i_sts.fin_empty) begin
                    n_state = fts_pkg::ST_EMPTY;
                end else if (i_sts.fin_tie) begin
                    n_state = fts_pkg::ST_TIE_RD0;
                end else begin
                    n_state = fts_pkg::ST_OUT_RD;
                end
            end
            fts_pkg::ST_EMPTY:   n_state = fts_pkg::ST_OUT_WAIT;
            fts_pkg::ST_TIE_RD0: n_state = fts_pkg::ST_TIE_RD1;
            fts_pkg::ST_TIE_RD1: n_state = fts_pkg::ST_TIE_CMP;
            fts_pkg::ST_TIE_CMP: n_state = fts_pkg::ST_OUT_RD;
            fts_pkg::ST_OUT_RD:  n_state = fts_pkg::ST_OUT_LD;
            fts_pkg::ST_OUT_LD:  n_state = fts_pkg::ST_OUT_WAIT;
            fts_pkg::ST_OUT_WAIT: begin
                if (i_sts.out_taken) begin
                    n_state = i_sts.out_final ? fts_pkg::ST_IDLE : fts_pkg::ST_OUT_RD;
                end
            end
            default: n_state = fts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.rsel = fts_pkg::RS_PREV;
        o_in_ready = 1'b0;
        unique case (r_state)
            fts_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            fts_pkg::ST_INS_RD: begin
                o_cmd.place = i_sts.at_zero;
            end
            fts_pkg::ST_INS_CMP: begin
                o_cmd.shift = i_sts.less;
                o_cmd.place = !i_sts.less;
            end
            fts_pkg::ST_FIN:     o_cmd.fin = 1'b1;
            fts_pkg::ST_EMPTY:   o_cmd.empty_load = 1'b1;
            fts_pkg::ST_TIE_RD0: o_cmd.rsel = fts_pkg::RS_KEEP;
            fts_pkg::ST_TIE_RD1: begin
                o_cmd.rsel    = fts_pkg::RS_KEEPM1;
                o_cmd.tie_cap = 1'b1;
            end
            fts_pkg::ST_TIE_CMP: o_cmd.tie_cmp = 1'b1;
            fts_pkg::ST_OUT_RD:  o_cmd.rsel = fts_pkg::RS_K;
            fts_pkg::ST_OUT_LD:  o_cmd.out_load = 1'b1;
            fts_pkg::ST_OUT_WAIT: ;
            default: ;
        endcase
    end
endmodule

// ----- src/fts_dp.sv -----
// ----------------------------------------------------------------------------
// Filtered top-N sorter datapath
// Selection cuts, ranked store, insertion pointer and result register.
// ----------------------------------------------------------------------------
`include "filtered_top_n_sorter_defines.svh"

module fts_dp #(
    parameter int STORE_DEPTH = fts_pkg::DefStoreDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fts_pkg::t_cfg     i_cfg,
    input  logic [12:0]       i_energy,
    input  logic [8:0]        i_eta,
    input  logic [6:0]        i_phi,
    input  logic [1:0]        i_iso,
    input  logic [1:0]        i_frac1,
    input  logic [1:0]        i_frac2,
    input  logic              i_last,
    input  fts_pkg::t_cmd     i_cmd,
    output fts_pkg::t_sts     o_sts,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [12:0]       o_energy,
    output logic [8:0]        o_eta,
    output logic [6:0]        o_phi,
    output logic              o_tie,
    output logic              o_list_empty,
    output logic              o_final_entry
);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    logic [12:0]   r_e;
    logic [8:0]    r_eta;
    logic [6:0]    r_phi;
    logic          r_last;
    logic [CW-1:0] r_fill, r_cnt, r_j, r_lim, r_emit, r_k;
    logic [12:0]   r_cmp_e;
    logic          r_tie;
    logic          r_ovalid;
    logic [12:0]   r_o_e;
    logic [8:0]    r_o_eta;
    logic [6:0]    r_o_phi;
    logic          r_o_tie, r_o_empty, r_o_final;

    logic [8:0]    mag;
    logic          pass;
    logic [15:0]   keep16, keepm1_16, fill16, lim16, cnt16, emit16, kp1_16, emitr16;
    logic [CW-1:0] j_m1;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [fts_pkg::EntryW-1:0] wdata, rdata;
    logic [12:0]   rd_e;
    logic          taken;

    assign mag  = i_eta[8] ? (9'd0 - i_eta) : i_eta;
    assign pass = (i_iso >= i_cfg.iso_min) && (i_frac1 >= i_cfg.frac1_min) &&
                  (i_frac2 >= i_cfg.frac2_min) && (mag >= {1'b0, i_cfg.eta_low}) &&
                  (mag <= {1'b0, i_cfg.eta_high});

    assign keep16    = {10'd0, i_cfg.keep_count};
    assign keepm1_16 = keep16 - 16'd1;
    assign fill16    = {{(16-CW){1'b0}}, r_fill};
    always_comb begin
        lim16 = (keep16 != 16'd0) ? keep16 + 16'd1 : 16'(STORE_DEPTH);
        if (lim16 > 16'(STORE_DEPTH)) begin
            lim16 = 16'(STORE_DEPTH);
        end
        cnt16  = (fill16 > lim16) ? lim16 : fill16;
        emit16 = o_sts.fin_tie ? keep16 : fill16;
        if (emit16 > 16'(fts_pkg::MaxResults)) begin
            emit16 = 16'(fts_pkg::MaxResults);
        end
    end
    assign kp1_16  = {{(16-CW){1'b0}}, r_k} + 16'd1;
    assign emitr16 = {{(16-CW){1'b0}}, r_emit};
    assign j_m1    = r_j - CW'(1);
    assign rd_e    = rdata[fts_pkg::EntryW-1 -: fts_pkg::EnergyW];
    assign taken   = r_ovalid && i_res_ready;

    always_comb begin
        case (i_cmd.rsel)
            fts_pkg::RS_PREV:   raddr = j_m1[AW-1:0];
            fts_pkg::RS_KEEP:   raddr = keep16[AW-1:0];
            fts_pkg::RS_KEEPM1: raddr = keepm1_16[AW-1:0];
            fts_pkg::RS_K:      raddr = r_k[AW-1:0];
            default:            raddr = r_k[AW-1:0];
        endcase
    end

    // A shifted entry moves down one slot; the entry at the hold limit falls off.
    assign we    = (i_cmd.shift || i_cmd.place) && (r_j < r_lim);
    assign waddr = r_j[AW-1:0];
    assign wdata = i_cmd.place ? {r_e, r_eta, r_phi} : rdata;

    fts_ram #(
        .WIDTH (fts_pkg::EntryW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.place) begin
                r_fill <= (r_cnt < r_lim) ? r_cnt + CW'(1) : r_lim;
            end else if (i_cmd.fin) begin
                r_fill <= '0;
            end
            if (i_cmd.out_load || i_cmd.empty_load) begin
                r_ovalid <= 1'b1;
            end else if (taken) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_e    <= i_energy;
            r_eta  <= i_eta;
            r_phi  <= i_phi;
            r_last <= i_last;
            r_cnt  <= cnt16[CW-1:0];
            r_j    <= cnt16[CW-1:0];
            r_lim  <= lim16[CW-1:0];
        end else if (i_cmd.shift) begin
            r_j <= j_m1;
        end
        if (i_cmd.fin) begin
            r_emit <= emit16[CW-1:0];
            r_k    <= '0;
            r_tie  <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.tie_cap) begin
            r_cmp_e <= rd_e;
        end
        if (i_cmd.tie_cmp) begin
            r_tie <= (rd_e == r_cmp_e);
        end
        if (i_cmd.out_load) begin
            r_o_e     <= rd_e;
            r_o_eta   <= rdata[fts_pkg::PhiW +: fts_pkg::EtaW];
            r_o_phi   <= rdata[fts_pkg::PhiW-1:0];
            r_o_tie   <= r_tie;
            r_o_empty <= 1'b0;
            r_o_final <= (kp1_16 == emitr16);
        end else if (i_cmd.empty_load) begin
            r_o_e     <= '0;
            r_o_eta   <= '0;
            r_o_phi   <= '0;
            r_o_tie   <= 1'b0;
            r_o_empty <= 1'b1;
            r_o_final <= 1'b1;
        end
    end

    assign o_sts.in_pass   = pass;
    assign o_sts.in_last   = i_last;
    assign o_sts.item_last = r_last;
    assign o_sts.at_zero   = (r_j == '0);
    assign o_sts.less      = (rd_e < r_e);
    assign o_sts.fin_empty = (r_fill == '0);
    assign o_sts.fin_tie   = (keep16 != 16'd0) && (fill16 > keep16);
    assign o_sts.out_taken = taken;
    assign o_sts.out_final = r_o_final;

    assign o_res_valid   = r_ovalid;
    assign o_energy      = r_o_e;
    assign o_eta         = r_o_eta;
    assign o_phi         = r_o_phi;
    assign o_tie         = r_o_tie;
    assign o_list_empty  = r_o_empty;
    assign o_final_entry = r_o_final;

    `FTS_ASSERT(a_fill_bound, r_fill <= CW'(STORE_DEPTH))
    `FTS_ASSERT_NEXT(a_fin_clears_fill, i_cmd.fin, r_fill == '0)
    `FTS_ASSERT(a_empty_is_final, (r_ovalid && r_o_empty) |-> r_o_final)
endmodule

// ----- src/filtered_top_n_sorter.sv -----
// ----------------------------------------------------------------------------
// Filtered top-N sorter
// Cuts trigger objects on quality and |eta|, ranks the survivors by energy.
// ----------------------------------------------------------------------------
// An object that fails the cuts is only taken; a passing object walks past
// the held entries it beats, with a read and a compare-and-shift per entry.
// After the last object the controller finishes, runs the tie check (read at N,
// read at N-1, compare) when more than N entries are held, then for each result
// reads, loads and waits for the transfer. An empty list gives its single result.
// Reset is synchronous and active low: the store is empty, registers default.
// ----------------------------------------------------------------------------
module filtered_top_n_sorter #(
    parameter int STORE_DEPTH = fts_pkg::DefStoreDepth
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    fts_obj_if.sink                    i_obj,
    fts_res_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fts_pkg::PAddrW-1:0] paddr,
    input  logic [fts_pkg::PDataW-1:0] pwdata,
    output logic [fts_pkg::PDataW-1:0] prdata,
    output logic                       pready
);
    // The register file holds the keep count and the selection cuts.
    fts_pkg::t_cfg cfg;
    fts_pkg::t_cmd cmd;
    fts_pkg::t_sts sts;
    logic          in_ready;

    fts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The controller accepts an object only while idle and then walks the
    // store from the tail, moving lower-energy entries down one slot until
    // the new object's place is found. Equal energies stop the walk, which
    // keeps arrival order among ties.
    fts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_obj.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_obj.ready = in_ready;

    // The datapath owns the ranked store and the result register; each
    // result transfer leaves from a register, so the sink may stall freely.
    fts_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_energy      (i_obj.energy),
        .i_eta         (i_obj.eta_pos),
        .i_phi         (i_obj.phi_pos),
        .i_iso         (i_obj.iso_word),
        .i_frac1       (i_obj.frac1_word),
        .i_frac2       (i_obj.frac2_word),
        .i_last        (i_obj.end_of_list),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_res_valid   (o_res.valid),
        .i_res_ready   (o_res.ready),
        .o_energy      (o_res.out_energy),
        .o_eta         (o_res.out_eta),
        .o_phi         (o_res.out_phi),
        .o_tie         (o_res.tie_at_cut),
        .o_list_empty  (o_res.list_empty),
        .o_final_entry (o_res.final_entry)
    );
endmodule

// ----- tb/fts_tb_ifs.sv -----
// ----------------------------------------------------------------------------
// Testbench clock helper
// Gives the sorter testbench a shared cycle counter for the watchdog.
// ----------------------------------------------------------------------------
interface fts_tb_tick_if (input logic clk);
    int unsigned idle_cycles;
endinterface

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Filtered top-N sorter testbench
// Drives trigger objects through the valid/ready channels and programs the
// cut registers over the APB port. A predictor keeps its own ranked list,
// and a scoreboard compares each ranked result with the oldest expectation.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [12:0]       energy;
    logic signed [8:0] eta;
    logic [6:0]        phi;
    logic              tie;
    logic              empty;
    logic              last;
} t_ranked_res;

typedef struct packed {
    logic [12:0]       energy;
    logic signed [8:0] eta;
    logic [6:0]        phi;
    logic [1:0]        iso;
    logic [1:0]        frac1;
    logic [1:0]        frac2;
    logic              eol;
} t_trig_obj;

// Predicts the ranked output of each event and checks what the block sends.
class rank_scoreboard;
    t_ranked_res   expected_q[$];
    int            mismatches;
    t_trig_obj     held[$];
    fts_pkg::t_cfg cfg;

    function new();
        cfg.keep_count = fts_pkg::RstKeep;
        cfg.eta_low    = fts_pkg::RstEtaLo;
        cfg.eta_high   = fts_pkg::RstEtaHi;
        cfg.iso_min    = 2'd0;
        cfg.frac1_min  = 2'd0;
        cfg.frac2_min  = 2'd0;
        mismatches     = 0;
    endfunction

    function int hold_limit();
        int lim;
        lim = (cfg.keep_count > 0) ? int'(cfg.keep_count) + 1 : fts_pkg::DefStoreDepth;
        return (lim > fts_pkg::DefStoreDepth) ? fts_pkg::DefStoreDepth : lim;
    endfunction

    // Notes an accepted object: filter, rank, and on end of list predict results.
    function void note_object(t_trig_obj obj);
        int          mag, lim, pos, n, emit;
        logic        tie;
        t_ranked_res r;
        mag = (obj.eta < 0) ? -int'(obj.eta) : int'(obj.eta);
        if (obj.iso >= cfg.iso_min && obj.frac1 >= cfg.frac1_min &&
            obj.frac2 >= cfg.frac2_min && mag >= cfg.eta_low && mag <= cfg.eta_high) begin
            lim = hold_limit();
            while (held.size() > lim) held.delete(held.size() - 1);
            pos = 0;
            while (pos < held.size() && held[pos].energy >= obj.energy) pos++;
            if (pos < lim) begin
                held.insert(pos, obj);
                if (held.size() > lim) held.delete(held.size() - 1);
            end
        end
        if (!obj.eol) return;
        r = '0;
        if (held.size() == 0) begin
            r.empty = 1'b1;
            r.last  = 1'b1;
            expected_q.insert(expected_q.size(), r);
            return;
        end
        n    = cfg.keep_count;
        emit = held.size();
        tie  = 1'b0;
        if (n > 0 && held.size() > n) begin
            emit = n;
            tie  = (held[n-1].energy == held[n].energy);
        end
        if (emit > fts_pkg::MaxResults) emit = fts_pkg::MaxResults;
        for (int k = 0; k < emit; k++) begin
            r.energy = held[k].energy;
            r.eta    = held[k].eta;
            r.phi    = held[k].phi;
            r.tie    = tie;
            r.empty  = 1'b0;
            r.last   = (k + 1 == emit);
            expected_q.insert(expected_q.size(), r);
        end
        held.delete();
    endfunction

    function void check_result(t_ranked_res got);
        t_ranked_res want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        want = expected_q.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
    endfunction
endclass

module testbench;
    localparam int WatchdogLimit = 20000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel, penable, pwrite, pready;
    logic [fts_pkg::PAddrW-1:0]  paddr;
    logic [fts_pkg::PDataW-1:0]  pwdata, prdata;

    fts_obj_if obj_ch();
    fts_res_if res_ch();
    fts_tb_tick_if tick (.clk(i_clk));

    filtered_top_n_sorter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_obj   (obj_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rank_scoreboard board;
    int  send_idle_pct;   // Percent of cycles the sender holds back.
    int  recv_idle_pct;   // Percent of cycles the receiver stalls.

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // The receiver decides its ready at every falling edge, so stalls land on
    // every phase of the block's output sequence.
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Results are sampled at the rising edge; a transfer takes place when
    // valid and ready are both high. The watchdog counts cycles with no transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                board.check_result({res_ch.out_energy, res_ch.out_eta, res_ch.out_phi,
                                    res_ch.tie_at_cut, res_ch.list_empty,
                                    res_ch.final_entry});
            end
            if ((res_ch.valid && res_ch.ready) || (obj_ch.valid && obj_ch.ready))
                tick.idle_cycles <= 0;
            else
                tick.idle_cycles <= tick.idle_cycles + 1;
            if (tick.idle_cycles >= WatchdogLimit) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Sends one object and holds it until the transfer; idles first at random.
    // Valid stays high afterwards so that the next object can follow at once;
    // the idle loop or the drain lowers it.
    task automatic send_object(t_trig_obj obj);
        while ($urandom_range(99) < send_idle_pct) begin
            obj_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        obj_ch.valid       <= 1'b1;
        obj_ch.energy      <= obj.energy;
        obj_ch.eta_pos     <= obj.eta;
        obj_ch.phi_pos     <= obj.phi;
        obj_ch.iso_word    <= obj.iso;
        obj_ch.frac1_word  <= obj.frac1;
        obj_ch.frac2_word  <= obj.frac2;
        obj_ch.end_of_list <= obj.eol;
        do @(posedge i_clk); while (!obj_ch.ready);
        board.note_object(obj);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        paddr   <= fts_pkg::PAddrW'(idx) << 2;
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            fts_pkg::REG_KEEP:  board.cfg.keep_count = value[5:0];
            fts_pkg::REG_ETALO: board.cfg.eta_low    = value[7:0];
            fts_pkg::REG_ETAHI: board.cfg.eta_high   = value[7:0];
            fts_pkg::REG_ISO:   board.cfg.iso_min    = value[1:0];
            fts_pkg::REG_FRAC1: board.cfg.frac1_min  = value[1:0];
            fts_pkg::REG_FRAC2: board.cfg.frac2_min  = value[1:0];
            default: ;
        endcase
    endtask

    task automatic program_cuts(int keep, int lo, int hi, int iso, int f1, int f2);
        write_reg(fts_pkg::REG_KEEP, keep);
        write_reg(fts_pkg::REG_ETALO, lo);
        write_reg(fts_pkg::REG_ETAHI, hi);
        write_reg(fts_pkg::REG_ISO, iso);
        write_reg(fts_pkg::REG_FRAC1, f1);
        write_reg(fts_pkg::REG_FRAC2, f2);
    endtask

    // Waits for the block to drain, then lets the last dropped object finish.
    task automatic wait_drained();
        obj_ch.valid <= 1'b0;
        while (board.expected_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    function automatic t_trig_obj random_object(logic eol, int e_max);
        t_trig_obj o;
        o.energy = 13'($urandom_range(e_max));
        o.eta    = 9'($urandom);
        o.phi    = 7'($urandom);
        o.iso    = 2'($urandom);
        o.frac1  = 2'($urandom);
        o.frac2  = 2'($urandom);
        o.eol    = eol;
        return o;
    endfunction

    // Random events: mostly short lists with a narrow energy range so that
    // ties and the keep cut are hit often; now and then an energy of any size.
    task automatic random_events(int count);
        int sent, len;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                send_object(random_object(k == len - 1,
                                          ($urandom_range(3) == 0) ? 8191 : 15));
                sent++;
            end
        end
    endtask

    initial begin
        t_trig_obj o;
        board         = new();
        send_idle_pct = 37;
        recv_idle_pct = 83;
        tick.idle_cycles = 0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        obj_ch.valid  = 1'b0;
        obj_ch.energy = '0;
        obj_ch.eta_pos = '0;
        obj_ch.phi_pos = '0;
        obj_ch.iso_word = '0;
        obj_ch.frac1_word = '0;
        obj_ch.frac2_word = '0;
        obj_ch.end_of_list = 1'b0;
        res_ch.ready  = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed part at reset settings: extremes of energy, eta and phi,
        // an eta of -256 which is always cut, an equal-energy tie, and an
        // empty list.
        o = '0; o.energy = 13'h1FFF; o.eta = 9'sd196; o.phi = 7'h7F; o.iso = 2'd3;
        o.frac1 = 2'd3; o.frac2 = 2'd3; send_object(o);
        o = '0; o.energy = 13'd0; o.eta = -9'sd196; send_object(o);
        o = '0; o.energy = 13'd5; o.eta = -9'sd256; send_object(o);
        o = '0; o.energy = 13'd5; o.eta = 9'sd197; send_object(o);
        o = '0; o.energy = 13'd7; o.phi = 7'd1; send_object(o);
        o = '0; o.energy = 13'd7; o.phi = 7'd2; o.eol = 1'b1; send_object(o);
        o = '0; o.eta = 9'sd255; o.eol = 1'b1; send_object(o);
        wait_drained();

        // Tight cuts and keep of one: quality minimums at the top, a narrow
        // eta window, and a tie right at the cut.
        program_cuts(1, 255, 255, 3, 3, 3);
        o = '0; o.energy = 13'd9; o.eta = 9'sd255; o.iso = 2'd3; o.frac1 = 2'd3;
        o.frac2 = 2'd3; send_object(o);
        o.phi = 7'd3; send_object(o);
        o.iso = 2'd2; send_object(o);
        o.iso = 2'd3; o.frac1 = 2'd2; send_object(o);
        o.frac1 = 2'd3; o.frac2 = 2'd2; o.eol = 1'b1; send_object(o);
        wait_drained();

        // Keep all: the store holds at most 64 entries, so one long event
        // fills the store to its depth.
        program_cuts(0, 0, 255, 0, 0, 0);
        for (int k = 0; k < 70; k++) send_object(random_object(k == 69, 8191));
        wait_drained();

        // Largest keep count, then keep lowered in the middle of an event.
        program_cuts(63, 0, 255, 0, 0, 0);
        for (int k = 0; k < 8; k++) send_object(random_object(1'b0, 15));
        wait_drained();
        write_reg(fts_pkg::REG_KEEP, 2);
        for (int k = 0; k < 4; k++) send_object(random_object(k == 3, 15));
        wait_drained();

        // Random part over several settings and idle mixes.
        program_cuts(3, 0, 196, 0, 0, 0);
        random_events(27);
        wait_drained();
        send_idle_pct = 83; recv_idle_pct = 37;
        program_cuts($urandom_range(1, 63), $urandom_range(40), $urandom_range(100, 255),
                     $urandom_range(1), $urandom_range(1), $urandom_range(1));
        random_events(27);
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        program_cuts(0, 0, 255, 1, 0, 2);
        random_events(27);
        wait_drained();

        if (board.mismatches == 0 && board.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ----- filtered_top_n_sorter.f -----
+incdir+src
src/fts_pkg.sv
src/fts_ifs.sv
src/fts_ram.sv
src/fts_cfg.sv
src/fts_ctrl.sv
src/fts_dp.sv
src/filtered_top_n_sorter.sv
tb/fts_tb_ifs.sv
tb/testbench.sv
